FILE: hw/rtl/spbc_pkg.sv
package spbc_pkg;

  // Kind of an input item, carried in s_axis_tuser.
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_ARC   = 1'b1
  } op_e;

  // Classification of one arc, carried in m_axis_tuser.
  typedef enum logic [1:0] {
    ST_SKIP     = 2'd0,
    ST_NO_CROSS = 2'd1,
    ST_CROSS    = 2'd2,
    ST_VERTEX   = 2'd3
  } status_e;

  // Comparisons against the first and the last plane in use, gathered on the way
  // through the cell row.
  typedef struct packed {
    logic d_gt_first;
    logic d_eq_first;
    logic o_lt_last;
    logic o_eq_last;
  } bound_flags_t;

  localparam int unsigned HEIGHT_W   = 32;
  localparam int unsigned ARC_W      = 24;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Register index, decoded from paddr[2].
  localparam logic REG_PLANE_COUNT = 1'b0;

endpackage

FILE: hw/rtl/slice_plane_bucket_classifier_unit.sv
// Throughput: one item per cycle; a row of MAX_PLANES cells, one plane each, then a lookup
// stage into the plane RAM and an output register, all advancing together on one enable.
// The pipeline stalls as a whole only while the output register holds an untaken result.
// Reset (rst_ni low, asynchronous) empties the pipeline and sets plane_count to 1; the
// plane table itself is not cleared and is undefined until written.
module slice_plane_bucket_classifier_unit #(
  parameter int unsigned MAX_PLANES = 256
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  // Input items.
  input  logic                                             s_axis_tvalid,
  output logic                                             s_axis_tready,
  // tdata, lowest bit up: plane_index, plane_height, arc_number, origin_height,
  // dest_height, zero fill.
  input  logic [((($clog2(MAX_PLANES) + 120) + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // tuser: operation.
  input  logic [0:0]                                       s_axis_tuser,
  // Result items.
  output logic                                             m_axis_tvalid,
  input  logic                                             m_axis_tready,
  // tdata, lowest bit up: arc_id_out, bucket, zero fill.
  output logic [((24 + $clog2(MAX_PLANES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // tuser: status.
  output logic [1:0]                                       m_axis_tuser,
  // Configuration.
  input  logic                                             psel,
  input  logic                                             penable,
  input  logic                                             pwrite,
  input  logic [spbc_pkg::APB_ADDR_W-1:0]                  paddr,
  input  logic [spbc_pkg::APB_DATA_W-1:0]                  pwdata,
  output logic [spbc_pkg::APB_DATA_W-1:0]                  prdata,
  output logic                                             pready
);

  localparam int unsigned IDX_W = $clog2(MAX_PLANES);
  localparam int unsigned CNT_W = $clog2(MAX_PLANES + 1);
  localparam int unsigned M_W   = ((24 + CNT_W + 7) / 8) * 8;
  localparam int unsigned HW    = spbc_pkg::HEIGHT_W;
  localparam int unsigned AW    = spbc_pkg::ARC_W;

  // Field offsets in s_axis_tdata.
  localparam int unsigned OFS_HEIGHT = IDX_W;
  localparam int unsigned OFS_ARC    = OFS_HEIGHT + HW;
  localparam int unsigned OFS_ORIGIN = OFS_ARC + AW;
  localparam int unsigned OFS_DEST   = OFS_ORIGIN + HW;

  logic                         en;
  logic [CNT_W-1:0]             plane_count_q;
  logic [CNT_W-1:0]             count_m1;
  logic [IDX_W-1:0]             last_idx;
  logic                         cfg_write;

  logic                         st_valid [MAX_PLANES+1];
  spbc_pkg::op_e                st_op    [MAX_PLANES+1];
  logic [IDX_W-1:0]             st_idx   [MAX_PLANES+1];
  logic signed [HW-1:0]         st_a     [MAX_PLANES+1];
  logic signed [HW-1:0]         st_d     [MAX_PLANES+1];
  logic [AW-1:0]                st_arc   [MAX_PLANES+1];
  logic [CNT_W-1:0]             st_cnt   [MAX_PLANES+1];
  spbc_pkg::bound_flags_t       st_flags [MAX_PLANES+1];

  logic                         out_valid;
  logic [AW-1:0]                out_arc;
  logic [CNT_W-1:0]             out_bucket;
  spbc_pkg::status_e            out_status;

  // Configuration register.
  assign cfg_write = psel && penable && pwrite && (paddr[2] == spbc_pkg::REG_PLANE_COUNT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_count_q <= CNT_W'(1);
    end else if (cfg_write) begin
      plane_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == spbc_pkg::REG_PLANE_COUNT) ?
                  spbc_pkg::APB_DATA_W'(plane_count_q) : '0;

  // Index of the last plane in use, with the count held to 1..MAX_PLANES.
  assign count_m1 = plane_count_q - CNT_W'(1);

  always_comb begin
    if (plane_count_q == '0) begin
      last_idx = '0;
    end else if (plane_count_q > CNT_W'(MAX_PLANES)) begin
      last_idx = IDX_W'(MAX_PLANES - 1);
    end else begin
      last_idx = count_m1[IDX_W-1:0];
    end
  end

  // The whole pipeline moves unless the output register holds an untaken result.
  assign en            = !out_valid || m_axis_tready;
  assign s_axis_tready = en;

  // Entry into the row. A write carries its height in the same lane as an origin.
  assign st_valid[0] = s_axis_tvalid;
  assign st_op[0]    = spbc_pkg::op_e'(s_axis_tuser[0]);
  assign st_idx[0]   = s_axis_tdata[IDX_W-1:0];
  assign st_a[0]     = (st_op[0] == spbc_pkg::OP_ARC) ? s_axis_tdata[OFS_ORIGIN +: HW]
                                                      : s_axis_tdata[OFS_HEIGHT +: HW];
  assign st_d[0]     = s_axis_tdata[OFS_DEST +: HW];
  assign st_arc[0]   = s_axis_tdata[OFS_ARC +: AW];
  assign st_cnt[0]   = '0;
  assign st_flags[0] = '0;

  // Row of cells, one plane and one pipeline stage each.
  for (genvar i = 0; i < MAX_PLANES; i++) begin : g_cell
    spbc_cell #(
      .CELL_IDX(i),
      .IDX_W   (IDX_W),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (en),
      .last_idx_i(last_idx),
      .valid_i   (st_valid[i]),
      .op_i      (st_op[i]),
      .idx_i     (st_idx[i]),
      .a_i       (st_a[i]),
      .d_i       (st_d[i]),
      .arc_i     (st_arc[i]),
      .cnt_i     (st_cnt[i]),
      .flags_i   (st_flags[i]),
      .valid_o   (st_valid[i+1]),
      .op_o      (st_op[i+1]),
      .idx_o     (st_idx[i+1]),
      .a_o       (st_a[i+1]),
      .d_o       (st_d[i+1]),
      .arc_o     (st_arc[i+1]),
      .cnt_o     (st_cnt[i+1]),
      .flags_o   (st_flags[i+1])
    );
  end

  // Plane lookup at the bucket, classification and output register.
  spbc_classify #(
    .MAX_PLANES(MAX_PLANES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_classify (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .last_idx_i(last_idx),
    .valid_i   (st_valid[MAX_PLANES]),
    .op_i      (st_op[MAX_PLANES]),
    .idx_i     (st_idx[MAX_PLANES]),
    .a_i       (st_a[MAX_PLANES]),
    .d_i       (st_d[MAX_PLANES]),
    .arc_i     (st_arc[MAX_PLANES]),
    .cnt_i     (st_cnt[MAX_PLANES]),
    .flags_i   (st_flags[MAX_PLANES]),
    .valid_o   (out_valid),
    .arc_o     (out_arc),
    .bucket_o  (out_bucket),
    .status_o  (out_status)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = M_W'({out_bucket, out_arc});
  assign m_axis_tuser  = out_status;

endmodule

FILE: hw/rtl/spbc_ram.sv
module spbc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/spbc_cell.sv
module spbc_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned IDX_W    = 8,
  parameter int unsigned CNT_W    = 9
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic [IDX_W-1:0]                        last_idx_i,
  input  logic                                    valid_i,
  input  spbc_pkg::op_e                           op_i,
  input  logic [IDX_W-1:0]                        idx_i,
  input  logic signed [spbc_pkg::HEIGHT_W-1:0]    a_i,
  input  logic signed [spbc_pkg::HEIGHT_W-1:0]    d_i,
  input  logic [spbc_pkg::ARC_W-1:0]              arc_i,
  input  logic [CNT_W-1:0]                        cnt_i,
  input  spbc_pkg::bound_flags_t                  flags_i,
  output logic                                    valid_o,
  output spbc_pkg::op_e                           op_o,
  output logic [IDX_W-1:0]                        idx_o,
  output logic signed [spbc_pkg::HEIGHT_W-1:0]    a_o,
  output logic signed [spbc_pkg::HEIGHT_W-1:0]    d_o,
  output logic [spbc_pkg::ARC_W-1:0]              arc_o,
  output logic [CNT_W-1:0]                        cnt_o,
  output spbc_pkg::bound_flags_t                  flags_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic signed [spbc_pkg::HEIGHT_W-1:0] plane_q;
  logic                                 valid_q;
  spbc_pkg::op_e                        op_q;
  logic [IDX_W-1:0]                     idx_q;
  logic signed [spbc_pkg::HEIGHT_W-1:0] a_q;
  logic signed [spbc_pkg::HEIGHT_W-1:0] d_q;
  logic [spbc_pkg::ARC_W-1:0]           arc_q;
  logic [CNT_W-1:0]                     cnt_d, cnt_q;
  spbc_pkg::bound_flags_t               flags_d, flags_q;
  logic                                 is_arc;
  logic                                 is_my_write;
  logic                                 in_use;
  logic                                 below;

  assign is_arc      = valid_i && (op_i == spbc_pkg::OP_ARC);
  assign is_my_write = valid_i && (op_i == spbc_pkg::OP_WRITE) && (idx_i == MY_IDX);
  assign in_use      = (MY_IDX <= last_idx_i);
  assign below       = (plane_q < a_i);

  // Count this plane if it is in use and lies below the origin, and record the
  // comparisons needed when this is the first or the last plane.
  always_comb begin
    cnt_d   = cnt_i + CNT_W'(is_arc && in_use && below);
    flags_d = flags_i;
    if (MY_IDX == '0) begin
      flags_d.d_gt_first = (d_i > plane_q);
      flags_d.d_eq_first = (d_i == plane_q);
    end
    if (MY_IDX == last_idx_i) begin
      flags_d.o_lt_last = (a_i < plane_q);
      flags_d.o_eq_last = (a_i == plane_q);
    end
  end

  // The plane entry is updated only when a write item passes this cell, so
  // items ahead and behind it see the table in item order.
  always_ff @(posedge clk_i) begin
    if (en_i && is_my_write) begin
      plane_q <= a_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q    <= op_i;
      idx_q   <= idx_i;
      a_q     <= a_i;
      d_q     <= d_i;
      arc_q   <= arc_i;
      cnt_q   <= cnt_d;
      flags_q <= flags_d;
    end
  end

  assign valid_o = valid_q;
  assign op_o    = op_q;
  assign idx_o   = idx_q;
  assign a_o     = a_q;
  assign d_o     = d_q;
  assign arc_o   = arc_q;
  assign cnt_o   = cnt_q;
  assign flags_o = flags_q;

endmodule

FILE: hw/rtl/spbc_classify.sv
module spbc_classify #(
  parameter int unsigned MAX_PLANES = 256,
  parameter int unsigned IDX_W      = 8,
  parameter int unsigned CNT_W      = 9
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic [IDX_W-1:0]                        last_idx_i,
  input  logic                                    valid_i,
  input  spbc_pkg::op_e                           op_i,
  input  logic [IDX_W-1:0]                        idx_i,
  input  logic signed [spbc_pkg::HEIGHT_W-1:0]    a_i,
  input  logic signed [spbc_pkg::HEIGHT_W-1:0]    d_i,
  input  logic [spbc_pkg::ARC_W-1:0]              arc_i,
  input  logic [CNT_W-1:0]                        cnt_i,
  input  spbc_pkg::bound_flags_t                  flags_i,
  output logic                                    valid_o,
  output logic [spbc_pkg::ARC_W-1:0]              arc_o,
  output logic [CNT_W-1:0]                        bucket_o,
  output spbc_pkg::status_e                       status_o
);

  logic [IDX_W-1:0]                     pick_idx;
  logic                                 ram_we;
  logic [spbc_pkg::HEIGHT_W-1:0]        plane_rd;
  logic signed [spbc_pkg::HEIGHT_W-1:0] pick_plane;

  logic                                 lk_valid_q;
  logic [spbc_pkg::ARC_W-1:0]           lk_arc_q;
  logic signed [spbc_pkg::HEIGHT_W-1:0] lk_a_q;
  logic signed [spbc_pkg::HEIGHT_W-1:0] lk_d_q;
  logic [CNT_W-1:0]                     lk_cnt_q;
  spbc_pkg::bound_flags_t               lk_flags_q;

  logic                                 rises;
  logic                                 in_span;
  spbc_pkg::status_e                    status_d;

  logic                                 out_valid_q;
  logic [spbc_pkg::ARC_W-1:0]           out_arc_q;
  logic [CNT_W-1:0]                     out_bucket_q;
  spbc_pkg::status_e                    out_status_q;

  // The plane at the bucket, held back to the last plane when every plane in
  // use lies below the origin.
  always_comb begin
    if (cnt_i > CNT_W'(last_idx_i)) begin
      pick_idx = last_idx_i;
    end else begin
      pick_idx = cnt_i[IDX_W-1:0];
    end
  end

  // Write items leave their height in the table copy at this point of the
  // pipeline, so arc items behind them read the new value.
  assign ram_we = en_i && valid_i && (op_i == spbc_pkg::OP_WRITE) &&
                  (CNT_W'(idx_i) < CNT_W'(MAX_PLANES));

  spbc_ram #(
    .WIDTH(spbc_pkg::HEIGHT_W),
    .DEPTH(MAX_PLANES)
  ) u_plane_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_i),
    .wdata_i(a_i),
    .re_i   (en_i),
    .raddr_i(pick_idx),
    .rdata_o(plane_rd)
  );

  assign pick_plane = plane_rd;

  // Lookup stage: only arc items go on, write items end here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lk_valid_q <= 1'b0;
    end else if (en_i) begin
      lk_valid_q <= valid_i && (op_i == spbc_pkg::OP_ARC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lk_arc_q   <= arc_i;
      lk_a_q     <= a_i;
      lk_d_q     <= d_i;
      lk_cnt_q   <= cnt_i;
      lk_flags_q <= flags_i;
    end
  end

  // Classification of the arc against the plane at its bucket.
  assign rises   = (lk_a_q < lk_d_q);
  assign in_span = rises && lk_flags_q.o_lt_last && lk_flags_q.d_gt_first;

  always_comb begin
    priority if (in_span && (lk_a_q == pick_plane)) begin
      status_d = spbc_pkg::ST_VERTEX;
    end else if (in_span && (lk_d_q > pick_plane)) begin
      status_d = spbc_pkg::ST_CROSS;
    end else if (in_span && (lk_d_q == pick_plane)) begin
      status_d = spbc_pkg::ST_VERTEX;
    end else if (in_span) begin
      status_d = spbc_pkg::ST_NO_CROSS;
    end else if (rises && (lk_flags_q.o_eq_last || lk_flags_q.d_eq_first)) begin
      status_d = spbc_pkg::ST_VERTEX;
    end else begin
      status_d = spbc_pkg::ST_SKIP;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= lk_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_arc_q    <= lk_arc_q;
      out_bucket_q <= lk_cnt_q;
      out_status_q <= status_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign arc_o    = out_arc_q;
  assign bucket_o = out_bucket_q;
  assign status_o = out_status_q;

endmodule

FILE: hw/rtl/spbc_checker.sv
module spbc_checker #(
  parameter int unsigned MAX_PLANES = 256
) (
  input logic                                                   clk_i,
  input logic                                                   rst_ni,
  input logic                                                   s_axis_tvalid,
  input logic                                                   s_axis_tready,
  input logic                                                   m_axis_tvalid,
  input logic                                                   m_axis_tready,
  input logic [((24 + $clog2(MAX_PLANES + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  input logic [1:0]                                             m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(MAX_PLANES + 1);

  logic [CNT_W-1:0] bucket;

  assign bucket = m_axis_tdata[24 +: CNT_W];

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // Input is refused only while the output register is blocked.
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input refused without output stall");

  // The bucket never counts more planes than the table holds.
  a_bucket_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> bucket <= CNT_W'(MAX_PLANES))
    else $error("bucket beyond table size");

  // An arc between the planes always has a plane at or above its origin.
  a_inside_bucket: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == spbc_pkg::ST_CROSS ||
                      m_axis_tuser == spbc_pkg::ST_NO_CROSS)
      |-> bucket < CNT_W'(MAX_PLANES))
    else $error("crossing reported with every plane below origin");

  // No result can come out right after reset.
  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("result present straight after reset");

endmodule

bind slice_plane_bucket_classifier_unit spbc_checker #(
  .MAX_PLANES(MAX_PLANES)
) u_spbc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
